/* hw/rtl/rfh_pkg.sv */
// Shared types, constants and CRC functions for the response frame hunter.
package rfh_pkg;

    localparam int unsigned DEF_MAX_PAYLOAD_WORDS = 64;
    localparam int unsigned DEF_MAX_HUNT_WORDS    = 1024;

    localparam int unsigned WORD_W     = 16;
    localparam int unsigned HDR_W      = 8;
    localparam int unsigned WIN_W      = 11;
    localparam int unsigned PAY_W      = 7;
    localparam int unsigned STATUS_W   = 3;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 11;
    localparam int unsigned QUEUE_DEPTH = 2;

    localparam logic [WORD_W-1:0] CRC_INIT = 16'hFFFF;
    localparam logic [WORD_W-1:0] CRC_POLY = 16'hA001;

    localparam logic [HDR_W-1:0] RST_EXPECTED_HEADER = 8'd0;
    localparam logic             RST_FULL_BYTE_MATCH = 1'b0;
    localparam logic             RST_NEED_NONZERO    = 1'b1;
    localparam logic [WIN_W-1:0] RST_HUNT_WINDOW     = 11'd64;
    localparam logic [PAY_W-1:0] RST_PAYLOAD_WORDS   = 7'd4;
    localparam logic             RST_CHECK_CRC       = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_EXPECTED_HEADER     = 3'd0,
        CFG_FULL_BYTE_MATCH     = 3'd1,
        CFG_NEED_NONZERO_SECOND = 3'd2,
        CFG_HUNT_WINDOW_WORDS   = 3'd3,
        CFG_PAYLOAD_WORDS       = 3'd4,
        CFG_CHECK_CRC           = 3'd5
    } t_cfg_idx;

    typedef enum logic [STATUS_W-1:0] {
        ST_HUNTING   = 3'd0,
        ST_CAPTURING = 3'd1,
        ST_DONE_OK   = 3'd2,
        ST_CRC_ERROR = 3'd3,
        ST_TIMEOUT   = 3'd4,
        ST_IGNORED   = 3'd5
    } t_status;

    typedef struct packed {
        logic [HDR_W-1:0] expected_header;
        logic             full_byte_match;
        logic             need_nonzero_second;
        logic [WIN_W-1:0] hunt_window_words;
        logic [PAY_W-1:0] payload_words;
        logic             check_crc;
    } t_cfg;

    // One classified word on its way from the front part to the back part.
    typedef struct packed {
        logic              is_word;
        logic              hdr_match;
        logic [WORD_W-1:0] word;
    } t_qent;

    function automatic logic [WORD_W-1:0] crc_byte(logic [WORD_W-1:0] crc,
                                                   logic [7:0] b);
        logic [WORD_W-1:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // Low byte goes first, which is the byte-swapped order of the wire.
    function automatic logic [WORD_W-1:0] crc_word(logic [WORD_W-1:0] crc,
                                                   logic [WORD_W-1:0] w);
        return crc_byte(crc_byte(crc, w[7:0]), w[15:8]);
    endfunction

endpackage

/* hw/rtl/rfh_if.sv */
// Channel interfaces: input words, result words and configuration writes.
interface rfh_in_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [15:0] rx_word;

    modport source (output valid, output req_type, output rx_word, input ready);
    modport sink   (input valid, input req_type, input rx_word, output ready);
endinterface

interface rfh_out_if #(
    parameter int unsigned IDX_W = 7
);
    logic             valid;
    logic             ready;
    logic [15:0]      data_word;
    logic             data_valid;
    logic [IDX_W-1:0] word_index;
    logic             frame_last;
    logic [2:0]       status;

    modport source (output valid, output data_word, output data_valid,
                    output word_index, output frame_last, output status, input ready);
    modport sink   (input valid, input data_word, input data_valid,
                    input word_index, input frame_last, input status, output ready);
endinterface

interface rfh_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  reg_index;
    logic [10:0] wdata;

    modport source (output valid, output reg_index, output wdata, input ready);
    modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

/* hw/rtl/rfh_front.sv */
// Front part: configuration registers, word acceptance and header classification.
module rfh_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    rfh_in_if.sink        i_in,
    rfh_cfg_if.sink       i_cfg,
    input  logic          i_q_ready,
    output logic          o_push,
    output rfh_pkg::t_qent o_entry,
    output rfh_pkg::t_cfg  o_cfg
);
    import rfh_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;
    logic [HDR_W-1:0] hi_byte;
    logic [HDR_W-1:0] lo_byte;
    logic             byte_hit;

    assign i_cfg.ready = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            unique case (i_cfg.reg_index)
                CFG_EXPECTED_HEADER:     n_cfg.expected_header = i_cfg.wdata[HDR_W-1:0];
                CFG_FULL_BYTE_MATCH:     n_cfg.full_byte_match = i_cfg.wdata[0];
                CFG_NEED_NONZERO_SECOND: n_cfg.need_nonzero_second = i_cfg.wdata[0];
                CFG_HUNT_WINDOW_WORDS:   n_cfg.hunt_window_words = i_cfg.wdata[WIN_W-1:0];
                CFG_PAYLOAD_WORDS:       n_cfg.payload_words = i_cfg.wdata[PAY_W-1:0];
                CFG_CHECK_CRC:           n_cfg.check_crc = i_cfg.wdata[0];
                default:                 n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.expected_header     <= RST_EXPECTED_HEADER;
            r_cfg.full_byte_match     <= RST_FULL_BYTE_MATCH;
            r_cfg.need_nonzero_second <= RST_NEED_NONZERO;
            r_cfg.hunt_window_words   <= RST_HUNT_WINDOW;
            r_cfg.payload_words       <= RST_PAYLOAD_WORDS;
            r_cfg.check_crc           <= RST_CHECK_CRC;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // In nibble mode an expected value above 15 can never match, since the
    // upper nibble of the compared value is forced to zero.
    assign hi_byte  = i_in.rx_word[15:8];
    assign lo_byte  = i_in.rx_word[7:0];
    assign byte_hit = r_cfg.full_byte_match ? (hi_byte == r_cfg.expected_header)
                    : ({4'h0, hi_byte[3:0]} == r_cfg.expected_header);

    assign i_in.ready        = i_q_ready;
    assign o_push            = i_in.valid && i_q_ready;
    assign o_entry.is_word   = i_in.req_type;
    assign o_entry.hdr_match = byte_hit && !(r_cfg.need_nonzero_second && (lo_byte == 8'h00));
    assign o_entry.word      = i_in.rx_word;
    assign o_cfg             = r_cfg;
endmodule

/* hw/rtl/rfh_queue.sv */
// Short register queue between the front and back parts.
module rfh_queue #(
    parameter int unsigned DEPTH = rfh_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  rfh_pkg::t_qent i_entry,
    output logic           o_not_full,
    output logic           o_valid,
    output rfh_pkg::t_qent o_entry,
    input  logic           i_pop
);
    import rfh_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_qent            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             do_push;
    logic             do_pop;

    assign o_not_full = (r_count != CNT_W'(DEPTH));
    assign o_valid    = (r_count != '0);
    assign o_entry    = r_mem[r_rd_ptr];
    assign do_push    = i_push && o_not_full;
    assign do_pop     = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end
endmodule

/* hw/rtl/rfh_back.sv */
// Back part: frame state machine, counters, running CRC and result register.
module rfh_back #(
    parameter int unsigned MAX_PAYLOAD_WORDS = rfh_pkg::DEF_MAX_PAYLOAD_WORDS,
    parameter int unsigned MAX_HUNT_WORDS    = rfh_pkg::DEF_MAX_HUNT_WORDS
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  rfh_pkg::t_cfg  i_cfg,
    input  logic           i_q_valid,
    input  rfh_pkg::t_qent i_q_entry,
    output logic           o_pop,
    rfh_out_if.source      o_out
);
    import rfh_pkg::*;

    localparam int unsigned IDX_W = $clog2(MAX_PAYLOAD_WORDS + 1);
    localparam int unsigned HC_W  = $clog2(MAX_HUNT_WORDS + 1);
    localparam int unsigned HCMP_W = (HC_W > WIN_W) ? HC_W : WIN_W;
    localparam int unsigned PCMP_W = (IDX_W > PAY_W) ? IDX_W : PAY_W;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'b001,
        PH_HUNT    = 3'b010,
        PH_CAPTURE = 3'b100
    } t_phase;

    t_phase            r_phase;
    t_phase            n_phase;
    logic [HC_W-1:0]   r_hunt_cnt;
    logic [HC_W-1:0]   n_hunt_cnt;
    logic [IDX_W-1:0]  r_cap_cnt;
    logic [IDX_W-1:0]  n_cap_cnt;
    logic [WORD_W-1:0] r_crc;
    logic [WORD_W-1:0] n_crc;

    logic              r_out_valid;
    logic              n_out_valid;
    logic [WORD_W-1:0] r_data_word;
    logic [WORD_W-1:0] n_data_word;
    logic              r_data_valid;
    logic              n_data_valid;
    logic [IDX_W-1:0]  r_word_index;
    logic [IDX_W-1:0]  n_word_index;
    logic              r_frame_last;
    logic              n_frame_last;
    t_status           r_status;
    t_status           n_status;

    logic [HC_W-1:0]   hunt_inc;
    logic [IDX_W-1:0]  cap_inc;
    logic [HCMP_W-1:0] win_raw;
    logic [HCMP_W-1:0] win_eff;
    logic [PCMP_W-1:0] pay_raw;
    logic [PCMP_W-1:0] pay_eff;
    logic [WORD_W-1:0] crc_step;

    // A result can be loaded whenever the output register is empty or drains.
    assign o_pop = i_q_valid && (!r_out_valid || o_out.ready);

    assign hunt_inc = (r_hunt_cnt < HC_W'(MAX_HUNT_WORDS)) ? r_hunt_cnt + HC_W'(1)
                                                          : r_hunt_cnt;
    assign cap_inc  = (r_cap_cnt < IDX_W'(MAX_PAYLOAD_WORDS)) ? r_cap_cnt + IDX_W'(1)
                                                             : r_cap_cnt;

    assign win_raw = HCMP_W'(i_cfg.hunt_window_words);
    assign win_eff = (win_raw == '0) ? HCMP_W'(1)
                   : (win_raw > HCMP_W'(MAX_HUNT_WORDS)) ? HCMP_W'(MAX_HUNT_WORDS) : win_raw;
    assign pay_raw = PCMP_W'(i_cfg.payload_words);
    assign pay_eff = (pay_raw == '0) ? PCMP_W'(1)
                   : (pay_raw > PCMP_W'(MAX_PAYLOAD_WORDS)) ? PCMP_W'(MAX_PAYLOAD_WORDS)
                   : pay_raw;

    // The header restarts the CRC; payload words extend the running value.
    assign crc_step = crc_word((r_phase == PH_HUNT) ? CRC_INIT : r_crc, i_q_entry.word);

    always_comb begin
        n_phase      = r_phase;
        n_hunt_cnt   = r_hunt_cnt;
        n_cap_cnt    = r_cap_cnt;
        n_crc        = r_crc;
        n_data_word  = '0;
        n_data_valid = 1'b0;
        n_word_index = '0;
        n_frame_last = 1'b0;
        n_status     = ST_IGNORED;
        if (!i_q_entry.is_word) begin
            n_phase    = PH_HUNT;
            n_hunt_cnt = '0;
            n_cap_cnt  = '0;
            n_crc      = CRC_INIT;
            n_status   = ST_HUNTING;
        end else begin
            unique case (r_phase)
                PH_HUNT: begin
                    n_hunt_cnt = hunt_inc;
                    if (i_q_entry.hdr_match) begin
                        n_phase      = PH_CAPTURE;
                        n_cap_cnt    = '0;
                        n_crc        = crc_step;
                        n_data_word  = i_q_entry.word;
                        n_data_valid = 1'b1;
                        n_status     = ST_CAPTURING;
                    end else if (HCMP_W'(hunt_inc) >= win_eff) begin
                        n_phase  = PH_IDLE;
                        n_status = ST_TIMEOUT;
                    end else begin
                        n_status = ST_HUNTING;
                    end
                end
                PH_CAPTURE: begin
                    n_cap_cnt    = cap_inc;
                    n_data_word  = i_q_entry.word;
                    n_data_valid = 1'b1;
                    n_word_index = cap_inc;
                    if (PCMP_W'(cap_inc) >= pay_eff) begin
                        n_phase      = PH_IDLE;
                        n_frame_last = 1'b1;
                        n_status     = (i_cfg.check_crc && (i_q_entry.word != r_crc))
                                     ? ST_CRC_ERROR : ST_DONE_OK;
                    end else begin
                        n_crc    = crc_step;
                        n_status = ST_CAPTURING;
                    end
                end
                default: begin
                    n_status = ST_IGNORED;
                end
            endcase
        end
    end

    assign n_out_valid = o_pop ? 1'b1 : (o_out.ready ? 1'b0 : r_out_valid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_hunt_cnt  <= '0;
            r_cap_cnt   <= '0;
            r_crc       <= CRC_INIT;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (o_pop) begin
                r_phase    <= n_phase;
                r_hunt_cnt <= n_hunt_cnt;
                r_cap_cnt  <= n_cap_cnt;
                r_crc      <= n_crc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_data_word  <= n_data_word;
            r_data_valid <= n_data_valid;
            r_word_index <= n_word_index;
            r_frame_last <= n_frame_last;
            r_status     <= n_status;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.data_word  = r_data_word;
    assign o_out.data_valid = r_data_valid;
    assign o_out.word_index = r_word_index;
    assign o_out.frame_last = r_frame_last;
    assign o_out.status     = r_status;
endmodule

/* hw/rtl/response_frame_hunter_crc16.sv */
// Top level of the response frame hunter with CRC-16/MODBUS frame check.
//
//   channel  | dir | handshake     | word carried
//   ---------+-----+---------------+------------------------------------------------
//   i_in     | in  | valid/ready   | req_type, rx_word
//   o_out    | out | valid/ready   | data_word, data_valid, word_index, frame_last, status
//   i_cfg    | in  | valid/ready   | reg_index, wdata (ready is always high)
//
// Every input word yields one result word; one word is taken per cycle while o_out
// is not stalled. The rate is set by the back part, which updates the running CRC
// by one whole word at a time. An input word passes the queue, then the output register.
// Reset is synchronous; it empties the queue and the output register, returns the
// frame state to idle and loads the register defaults. While o_out is stalled the
// two-entry queue fills, after which i_in.ready drops.
module response_frame_hunter_crc16 #(
    parameter int unsigned MAX_PAYLOAD_WORDS = rfh_pkg::DEF_MAX_PAYLOAD_WORDS,
    parameter int unsigned MAX_HUNT_WORDS    = rfh_pkg::DEF_MAX_HUNT_WORDS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rfh_in_if.sink     i_in,
    rfh_cfg_if.sink    i_cfg,
    rfh_out_if.source  o_out
);
    import rfh_pkg::*;

    localparam int unsigned IDX_W = $clog2(MAX_PAYLOAD_WORDS + 1);

    t_cfg  cfg;
    t_qent push_entry;
    t_qent pop_entry;
    logic  push;
    logic  q_not_full;
    logic  q_valid;
    logic  pop;

    rfh_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_cfg     (i_cfg),
        .i_q_ready (q_not_full),
        .o_push    (push),
        .o_entry   (push_entry),
        .o_cfg     (cfg)
    );

    rfh_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_entry    (push_entry),
        .o_not_full (q_not_full),
        .o_valid    (q_valid),
        .o_entry    (pop_entry),
        .i_pop      (pop)
    );

    rfh_back #(
        .MAX_PAYLOAD_WORDS (MAX_PAYLOAD_WORDS),
        .MAX_HUNT_WORDS    (MAX_HUNT_WORDS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_q_valid (q_valid),
        .i_q_entry (pop_entry),
        .o_pop     (pop),
        .o_out     (o_out)
    );
endmodule

/* hw/rtl/rfh_checker.sv */
// Port-level assertions for the response frame hunter and their bind.
module rfh_checker #(
    parameter int unsigned IDX_W = 7
) (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input logic [15:0]      i_data_word,
    input logic             i_data_valid,
    input logic [IDX_W-1:0] i_word_index,
    input logic             i_frame_last,
    input logic [2:0]       i_status
);
    import rfh_pkg::*;

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_data_word)
            && $stable(i_status) && $stable(i_word_index))
        else $error("result word changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    a_last_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_frame_last |-> i_data_valid
            && (i_status == ST_DONE_OK || i_status == ST_CRC_ERROR))
        else $error("frame end without a final status");

    a_no_data_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_data_valid |-> i_data_word == '0 && i_word_index == '0
            && !i_frame_last)
        else $error("fields set on a word outside a frame");

    a_end_has_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status == ST_DONE_OK || i_status == ST_CRC_ERROR)
            |-> i_frame_last && i_word_index != '0)
        else $error("final status on a word that is not the frame end");
endmodule

bind response_frame_hunter_crc16 rfh_checker #(
    .IDX_W (IDX_W)
) u_rfh_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_data_word  (o_out.data_word),
    .i_data_valid (o_out.data_valid),
    .i_word_index (o_out.word_index),
    .i_frame_last (o_out.frame_last),
    .i_status     (o_out.status)
);

/* tb/sv/testbench.sv */
// Testbench for the response frame hunter: random frames and noise against a predictor.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import rfh_pkg::*;

    localparam int unsigned HUNT_LIMIT    = DEF_MAX_HUNT_WORDS;
    localparam int unsigned PAYLOAD_LIMIT = DEF_MAX_PAYLOAD_WORDS;
    localparam int unsigned IDLE_LIMIT    = 2000;
    localparam int unsigned PHASE_WORDS   = 55;

    typedef enum logic [1:0] {
        FR_IDLE,
        FR_HUNT,
        FR_CAPTURE
    } t_frame_phase;

    typedef struct packed {
        logic        req;
        logic [15:0] word;
    } t_rx_item;

    typedef struct packed {
        logic [15:0] data_word;
        logic        data_valid;
        logic [6:0]  word_index;
        logic        frame_last;
        t_status     status;
    } t_frame_result;

    logic clk = 1'b0;
    logic rst_n;

    rfh_in_if  in_ch ();
    rfh_cfg_if cfg_ch ();
    rfh_out_if out_ch ();

    response_frame_hunter_crc16 u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .i_cfg   (cfg_ch),
        .o_out   (out_ch)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Predictor state and its copy of the registers.
    t_cfg          hunt_cfg;
    t_frame_phase  frame_phase;
    int unsigned   words_hunted;
    int unsigned   words_captured;
    logic [15:0]   crc_acc;

    t_rx_item      words_to_send[$];
    t_frame_result frame_results_due[$];
    int unsigned   words_queued;
    int unsigned   mismatch_count;

    int unsigned   burst_left;
    int unsigned   gap_left;
    logic [7:0]    ready_pattern;
    int unsigned   pattern_age;
    int unsigned   idle_cycles;

    // Reflected CRC-16 fed bit by bit, low byte first, which is the byte-swapped wire order.
    function automatic logic [15:0] modbus_crc_word(logic [15:0] crc, logic [15:0] w);
        logic [15:0] c;
        c = crc;
        for (int b = 0; b < 16; b++) begin
            c = (c[0] ^ w[b]) ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic int unsigned eff_window();
        if (hunt_cfg.hunt_window_words == 0) return 1;
        if (hunt_cfg.hunt_window_words > HUNT_LIMIT) return HUNT_LIMIT;
        return hunt_cfg.hunt_window_words;
    endfunction

    function automatic int unsigned eff_payload();
        if (hunt_cfg.payload_words == 0) return 1;
        if (hunt_cfg.payload_words > PAYLOAD_LIMIT) return PAYLOAD_LIMIT;
        return hunt_cfg.payload_words;
    endfunction

    function automatic bit header_hit(logic [15:0] w);
        bit hit;
        if (hunt_cfg.full_byte_match)
            hit = (w[15:8] == hunt_cfg.expected_header);
        else
            hit = ({4'h0, w[11:8]} == hunt_cfg.expected_header);
        if (hunt_cfg.need_nonzero_second && w[7:0] == 8'h00)
            hit = 1'b0;
        return hit;
    endfunction

    function automatic t_frame_result hunt_frame_word(logic req, logic [15:0] w);
        t_frame_result r;
        r = '0;
        r.status = ST_HUNTING;
        if (!req) begin
            frame_phase = FR_HUNT;
            words_hunted = 0;
            words_captured = 0;
            crc_acc = CRC_INIT;
            return r;
        end
        case (frame_phase)
            FR_HUNT: begin
                if (words_hunted < HUNT_LIMIT) words_hunted++;
                if (header_hit(w)) begin
                    frame_phase = FR_CAPTURE;
                    words_captured = 0;
                    crc_acc = modbus_crc_word(CRC_INIT, w);
                    r.data_word = w;
                    r.data_valid = 1'b1;
                    r.status = ST_CAPTURING;
                end else if (words_hunted >= eff_window()) begin
                    frame_phase = FR_IDLE;
                    r.status = ST_TIMEOUT;
                end
            end
            FR_CAPTURE: begin
                if (words_captured < PAYLOAD_LIMIT) words_captured++;
                r.data_word = w;
                r.data_valid = 1'b1;
                r.word_index = 7'(words_captured);
                if (words_captured >= eff_payload()) begin
                    r.frame_last = 1'b1;
                    r.status = (hunt_cfg.check_crc && w != crc_acc) ? ST_CRC_ERROR : ST_DONE_OK;
                    frame_phase = FR_IDLE;
                end else begin
                    crc_acc = modbus_crc_word(crc_acc, w);
                    r.status = ST_CAPTURING;
                end
            end
            default: r.status = ST_IGNORED;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string what, t_frame_result want, t_frame_result got);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("%s at %0t: expected word=%h valid=%b index=%0d last=%b status=%0d,",
                     what, $time, want.data_word, want.data_valid, want.word_index,
                     want.frame_last, want.status);
            $display("    got word=%h valid=%b index=%0d last=%b status=%0d",
                     got.data_word, got.data_valid, got.word_index, got.frame_last,
                     got.status);
        end
    endtask

    // Word sender: bursts of random length separated by random gaps.
    always @(posedge clk) begin : send_words
        t_rx_item item;
        if (!rst_n) begin
            in_ch.valid    <= 1'b0;
            in_ch.req_type <= 1'b0;
            in_ch.rx_word  <= '0;
            burst_left = 0;
            gap_left = 0;
        end else if (!in_ch.valid || in_ch.ready) begin
            if (gap_left > 0 || words_to_send.size() == 0) begin
                in_ch.valid <= 1'b0;
                if (gap_left > 0) gap_left--;
            end else begin
                item = words_to_send.pop_front();
                in_ch.valid    <= 1'b1;
                in_ch.req_type <= item.req;
                in_ch.rx_word  <= item.word;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
                    burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                             : $urandom_range(0, 8);
                end
            end
        end
    end

    // Result receiver: ready follows a rotating pattern that is reloaded now and then.
    always @(posedge clk) begin : sink_stalls
        logic [7:0] pat;
        if (!rst_n) begin
            out_ch.ready  <= 1'b0;
            ready_pattern <= 8'hFF;
            pattern_age   <= 0;
        end else begin
            pat = {ready_pattern[0], ready_pattern[7:1]};
            if (pattern_age == 40)
                pat = ($urandom_range(0, 3) == 0) ? 8'hFF : (8'($urandom()) | 8'h01);
            out_ch.ready  <= ready_pattern[0];
            ready_pattern <= pat;
            pattern_age   <= (pattern_age == 40) ? 0 : pattern_age + 1;
        end
    end

    // Checks each result word, then predicts for the word taken at this edge.
    always @(posedge clk) begin : check_results
        t_frame_result got;
        t_frame_result want;
        if (rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                got.data_word  = out_ch.data_word;
                got.data_valid = out_ch.data_valid;
                got.word_index = out_ch.word_index;
                got.frame_last = out_ch.frame_last;
                got.status     = t_status'(out_ch.status);
                if (frame_results_due.size() == 0) begin
                    report_mismatch("result with nothing expected", '0, got);
                end else begin
                    want = frame_results_due.pop_front();
                    if (got.data_word !== want.data_word || got.data_valid !== want.data_valid ||
                        got.word_index !== want.word_index ||
                        got.frame_last !== want.frame_last || got.status !== want.status)
                        report_mismatch("wrong result", want, got);
                end
            end
            if (in_ch.valid && in_ch.ready)
                frame_results_due.push_back(hunt_frame_word(in_ch.req_type, in_ch.rx_word));
        end
    end

    always @(posedge clk) begin : watchdog
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("response_frame_hunter_crc16: mismatch");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic push_word(logic req, logic [15:0] w);
        words_to_send.push_back('{req: req, word: w});
        words_queued++;
    endtask

    function automatic logic [15:0] pick_noise();
        logic [15:0] w;
        do w = 16'($urandom()); while (header_hit(w));
        return w;
    endfunction

    function automatic logic [15:0] pick_header();
        logic [15:0] w;
        w = 16'($urandom());
        if (hunt_cfg.full_byte_match)
            w[15:8] = hunt_cfg.expected_header;
        else
            w[11:8] = hunt_cfg.expected_header[3:0];
        if (hunt_cfg.need_nonzero_second && w[7:0] == 8'h00)
            w[7:0] = 8'($urandom_range(1, 255));
        return w;
    endfunction

    // Header plus up to cut payload words; an uncut frame's last word carries the CRC when checking.
    task automatic push_body(logic [15:0] hdr, bit crc_good, int unsigned cut);
        logic [15:0] crc;
        logic [15:0] w;
        int unsigned n;
        n = eff_payload();
        push_word(1'b1, hdr);
        crc = modbus_crc_word(CRC_INIT, hdr);
        for (int unsigned k = 1; k <= n && k <= cut; k++) begin
            if (k == n && hunt_cfg.check_crc) begin
                w = crc;
                if (!crc_good) w ^= 16'(1 << $urandom_range(0, 15));
            end else begin
                case ($urandom_range(0, 7))
                    0:       w = 16'hFFFF;
                    1:       w = 16'h0000;
                    default: w = 16'($urandom());
                endcase
                crc = modbus_crc_word(crc, w);
            end
            push_word(1'b1, w);
        end
    endtask

    task automatic push_frame(int unsigned noise_n, bit crc_good, int unsigned cut);
        push_word(1'b0, 16'($urandom()));
        repeat (noise_n) push_word(1'b1, pick_noise());
        push_body(pick_header(), crc_good, cut);
    endtask

    function automatic int unsigned noise_before_header();
        return $urandom_range(0, (eff_window() > 4) ? 4 : eff_window() - 1);
    endfunction

    task automatic wait_drained();
        while (words_to_send.size() != 0 || in_ch.valid || frame_results_due.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic apply_settings(t_cfg s);
        logic [10:0] val;
        for (int k = 0; k <= int'(CFG_CHECK_CRC); k++) begin
            case (t_cfg_idx'(k))
                CFG_EXPECTED_HEADER:     val = 11'(s.expected_header);
                CFG_FULL_BYTE_MATCH:     val = 11'(s.full_byte_match);
                CFG_NEED_NONZERO_SECOND: val = 11'(s.need_nonzero_second);
                CFG_HUNT_WINDOW_WORDS:   val = s.hunt_window_words;
                CFG_PAYLOAD_WORDS:       val = 11'(s.payload_words);
                default:                 val = 11'(s.check_crc);
            endcase
            cfg_ch.valid     <= 1'b1;
            cfg_ch.reg_index <= t_cfg_idx'(k);
            cfg_ch.wdata     <= val;
            do @(posedge clk); while (!cfg_ch.ready);
        end
        cfg_ch.valid <= 1'b0;
        hunt_cfg = s;
    endtask

    function automatic t_cfg random_settings();
        t_cfg s;
        s.full_byte_match = 1'($urandom());
        if (s.full_byte_match || $urandom_range(0, 4) == 0)
            s.expected_header = 8'($urandom());
        else
            s.expected_header = 8'($urandom_range(0, 15));
        s.need_nonzero_second = 1'($urandom());
        case ($urandom_range(0, 9))
            0:       s.hunt_window_words = 11'd0;
            1:       s.hunt_window_words = 11'($urandom_range(1, 64));
            default: s.hunt_window_words = 11'($urandom_range(1, 20));
        endcase
        s.payload_words = ($urandom_range(0, 9) == 0) ? 7'd0 : 7'($urandom_range(1, 10));
        s.check_crc = ($urandom_range(0, 9) < 7);
        return s;
    endfunction

    // Settles the block, loads new settings, then queues frames and noise under them.
    task automatic run_phase(t_cfg s, int unsigned budget);
        int unsigned first;
        int unsigned pick;
        wait_drained();
        @(posedge clk);
        apply_settings(s);
        @(negedge clk);
        first = words_queued;
        // Stray words may land in a frame left open by the previous settings.
        repeat ($urandom_range(0, 2)) push_word(1'b1, 16'($urandom()));
        while (words_queued - first < budget) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                push_frame(noise_before_header(), $urandom_range(0, 4) != 0, eff_payload());
            end else if (pick < 72) begin
                if (eff_window() <= 64) begin
                    push_word(1'b0, 16'($urandom()));
                    repeat (eff_window()) push_word(1'b1, pick_noise());
                end
            end else if (pick < 85) begin
                push_frame(noise_before_header(), 1'b1, $urandom_range(0, eff_payload() - 1));
            end else begin
                repeat ($urandom_range(1, 6))
                    push_word($urandom_range(0, 7) != 0, 16'($urandom()));
            end
        end
        // Sometimes leave a hunt or a capture open across the next register change.
        case ($urandom_range(0, 2))
            1: push_frame(0, 1'b1, $urandom_range(0, eff_payload() - 1));
            2: begin
                push_word(1'b0, 16'($urandom()));
                repeat ($urandom_range(1, 3)) push_word(1'b1, pick_noise());
            end
            default: ;
        endcase
    endtask

    initial begin : stimulus
        t_cfg corner_settings[6];
        // header, full byte, nonzero second, window, payload, check
        corner_settings = '{
            '{8'h5A, 1'b1, 1'b0, 11'd1,    7'd1,   1'b1},
            '{8'h03, 1'b0, 1'b1, 11'd0,    7'd0,   1'b0},
            '{8'hFF, 1'b1, 1'b0, 11'd1024, 7'd64,  1'b1},
            '{8'h20, 1'b0, 1'b0, 11'd5,    7'd2,   1'b1},
            '{8'hA5, 1'b1, 1'b1, 11'd2047, 7'd127, 1'b1},
            '{8'h0F, 1'b0, 1'b1, 11'd3,    7'd2,   1'b0}
        };
        rst_n            = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.req_type   = 1'b0;
        in_ch.rx_word    = '0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.reg_index = CFG_EXPECTED_HEADER;
        cfg_ch.wdata     = '0;
        out_ch.ready     = 1'b0;
        words_queued     = 0;
        mismatch_count   = 0;
        hunt_cfg = '{RST_EXPECTED_HEADER, RST_FULL_BYTE_MATCH, RST_NEED_NONZERO,
                     RST_HUNT_WINDOW, RST_PAYLOAD_WORDS, RST_CHECK_CRC};
        frame_phase    = FR_IDLE;
        words_hunted   = 0;
        words_captured = 0;
        crc_acc        = CRC_INIT;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part under the reset settings.
        push_word(1'b1, 16'hFFFF);              // word before any poll is ignored
        push_word(1'b0, 16'hFFFF);
        push_word(1'b1, 16'h0000);              // nibble matches but second byte is zero
        push_word(1'b1, 16'h1F80);
        push_body(16'hF001, 1'b1, eff_payload());
        push_word(1'b1, 16'h0000);              // after the frame ends the block is idle
        push_word(1'b0, 16'h0000);
        push_body(16'h00FF, 1'b0, eff_payload());
        push_word(1'b0, 16'h1234);
        push_body(16'h10A0, 1'b1, 2);
        push_word(1'b0, 16'hABCD);              // a poll abandons the open capture
        push_body(16'hE07F, 1'b1, eff_payload());

        foreach (corner_settings[p])
            run_phase(corner_settings[p], PHASE_WORDS);
        repeat (6)
            run_phase(random_settings(), PHASE_WORDS);

        wait_drained();
        repeat (4) @(posedge clk);
        if (mismatch_count == 0)
            $display("response_frame_hunter_crc16: match");
        else
            $display("response_frame_hunter_crc16: mismatch");
        $finish;
    end

endmodule
